// ===== design/sps_pkg.sv =====
// Shared types, syntax step codes and helpers for the SPS frame-size parser.
// No dependencies; sps_dp, sps_ctrl, the top level and sps_chk import this package.
`default_nettype none
package sps_pkg;

  localparam int DIM_BITS_DEF = 16;

  // syntax walker steps
  localparam logic [5:0] ST_HEADER     = 6'd0;
  localparam logic [5:0] ST_FIXED      = 6'd1;
  localparam logic [5:0] ST_SPS_ID     = 6'd2;
  localparam logic [5:0] ST_CHROMA     = 6'd3;
  localparam logic [5:0] ST_SEPARATE   = 6'd4;
  localparam logic [5:0] ST_DEPTH_L    = 6'd5;
  localparam logic [5:0] ST_DEPTH_C    = 6'd6;
  localparam logic [5:0] ST_BYPASS     = 6'd7;
  localparam logic [5:0] ST_MATRIX     = 6'd8;
  localparam logic [5:0] ST_LIST_FLAG  = 6'd9;
  localparam logic [5:0] ST_LIST_DELTA = 6'd10;
  localparam logic [5:0] ST_FRAME_NUM  = 6'd11;
  localparam logic [5:0] ST_POC_TYPE   = 6'd12;
  localparam logic [5:0] ST_POC_LSB    = 6'd13;
  localparam logic [5:0] ST_POC_ZERO   = 6'd14;
  localparam logic [5:0] ST_POC_NONREF = 6'd15;
  localparam logic [5:0] ST_POC_TB     = 6'd16;
  localparam logic [5:0] ST_POC_COUNT  = 6'd17;
  localparam logic [5:0] ST_POC_REF    = 6'd18;
  localparam logic [5:0] ST_MAX_REF    = 6'd19;
  localparam logic [5:0] ST_GAPS       = 6'd20;
  localparam logic [5:0] ST_WIDTH      = 6'd21;
  localparam logic [5:0] ST_HEIGHT     = 6'd22;
  localparam logic [5:0] ST_FMO        = 6'd23;
  localparam logic [5:0] ST_MBAFF      = 6'd24;
  localparam logic [5:0] ST_DIRECT     = 6'd25;
  localparam logic [5:0] ST_CROP_FLAG  = 6'd26;
  localparam logic [5:0] ST_CROP_L     = 6'd27;
  localparam logic [5:0] ST_CROP_B     = 6'd30;
  localparam logic [5:0] ST_DONE       = 6'd31;
  localparam logic [5:0] ST_DRAIN      = 6'd32;

  // result status codes
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_SKIPPED  = 3'd1;
  localparam logic [2:0] STS_NOT_SPS  = 3'd2;
  localparam logic [2:0] STS_BAD_FLD  = 3'd3;
  localparam logic [2:0] STS_TRUNC    = 3'd4;
  localparam logic [2:0] STS_RANGE    = 3'd5;

  typedef struct packed {
    logic       load;
    logic       byte_step;
    logic       bit_step;
    logic [2:0] bit_sel;
    logic       finish;
  } sps_cmd_t;

  typedef struct packed {
    logic need_bits;
    logic last;
  } sps_sts_t;

  // steps whose syntax element is ue(v)/se(v) coded
  function automatic logic is_ue(input logic [5:0] s);
    case (s) inside
      ST_SPS_ID, ST_CHROMA, ST_DEPTH_L, ST_DEPTH_C, ST_LIST_DELTA, ST_FRAME_NUM,
      ST_POC_TYPE, ST_POC_LSB, ST_POC_NONREF, ST_POC_TB, ST_POC_COUNT,
      ST_POC_REF, ST_MAX_REF, ST_WIDTH, ST_HEIGHT,
      [ST_CROP_L:ST_CROP_B]: is_ue = 1'b1;
      default:                is_ue = 1'b0;
    endcase
  endfunction

  function automatic logic high_profile(input logic [7:0] p);
    high_profile = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) ||
                   (p == 8'd244) || (p == 8'd44) || (p == 8'd83) ||
                   (p == 8'd86) || (p == 8'd118) || (p == 8'd128);
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/sps_if.sv =====
// Valid/ready channel interfaces for the SPS parser input and result items.
// No dependencies.
`default_nettype none
interface sps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] nal_byte;
  logic       last_byte;
  modport source(output valid, nal_byte, last_byte, input ready);
  modport sink(input valid, nal_byte, last_byte, output ready);
endinterface

interface sps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic [7:0]  profile_code;
  logic [7:0]  level_code;
  logic [4:0]  set_id;
  logic [1:0]  chroma_format;
  modport source(output valid, status, frame_width, frame_height, profile_code,
                 level_code, set_id, chroma_format, input ready);
  modport sink(input valid, status, frame_width, frame_height, profile_code,
               level_code, set_id, chroma_format, output ready);
endinterface
`default_nettype wire

// ===== design/sps_dp.sv =====
// Datapath: byte capture, emulation-prevention removal, Exp-Golomb walker,
// syntax state, size computation and result register. Uses sps_pkg.
`default_nettype none
module sps_dp #(
  parameter int DIM_BITS = sps_pkg::DIM_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  input  wire logic [7:0]       nal_byte,
  input  wire logic             last_byte,
  input  wire sps_pkg::sps_cmd_t cmd,
  output sps_pkg::sps_sts_t     sts,
  output logic [2:0]            status,
  output logic [15:0]           frame_width,
  output logic [15:0]           frame_height,
  output logic [7:0]            profile_code,
  output logic [7:0]            level_code,
  output logic [4:0]            set_id,
  output logic [1:0]            chroma_format
);
  import sps_pkg::*;

  localparam int LIM = (DIM_BITS >= 16) ? 65535 : ((1 << DIM_BITS) - 1);

  logic        en_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [5:0]  step_r, step_nxt;
  logic [1:0]  zrun_r, zrun_nxt;
  logic [1:0]  bidx_r, bidx_nxt;
  logic [4:0]  lz_r, lz_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [4:0]  rem_r, rem_nxt;
  logic [7:0]  loop_r, loop_nxt;
  logic [6:0]  spos_r, spos_nxt;
  logic [7:0]  nscale_r, nscale_nxt;
  logic [15:0] wu_r, wu_nxt, hu_r, hu_nxt;
  logic [15:0] crop_r [4];
  logic [15:0] crop_nxt [4];
  logic        fmo_r, fmo_nxt, sep_r, sep_nxt, sfx_r, sfx_nxt;
  logic [7:0]  prof_r, prof_nxt, lvl_r, lvl_nxt;
  logic [4:0]  id_r, id_nxt;
  logic [1:0]  chr_r, chr_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        epb, active, bit_in, tv_en;
  logic [31:0] tv, acc_s;
  logic [7:0]  ns, lp1, lists;
  logic [6:0]  sp1;
  logic [5:0]  crop_off;

  assign epb    = (zrun_r == 2'd2) && (byte_r == 8'h03);
  assign active = (step_r != ST_DONE) && (step_r != ST_DRAIN);
  assign sts.need_bits = (step_r != ST_HEADER) && (step_r != ST_FIXED) && active && !epb;
  assign sts.last = last_r;

  assign bit_in   = byte_r[cmd.bit_sel];
  assign acc_s    = {acc_r[30:0], bit_in};
  assign lp1      = loop_r + 8'd1;
  assign lists    = (chr_r != 2'd3) ? 8'd8 : 8'd12;
  assign sp1      = spos_r + 7'd1;
  assign crop_off = step_r - ST_CROP_L;

  always_comb begin
    step_nxt = step_r; zrun_nxt = zrun_r; bidx_nxt = bidx_r; lz_nxt = lz_r;
    acc_nxt = acc_r; rem_nxt = rem_r; loop_nxt = loop_r; spos_nxt = spos_r;
    nscale_nxt = nscale_r; wu_nxt = wu_r; hu_nxt = hu_r;
    for (int i = 0; i < 4; i++) crop_nxt[i] = crop_r[i];
    fmo_nxt = fmo_r; sep_nxt = sep_r; sfx_nxt = sfx_r;
    prof_nxt = prof_r; lvl_nxt = lvl_r; id_nxt = id_r; chr_nxt = chr_r;
    err_nxt = err_r;
    tv_en = 1'b0; tv = '0; ns = nscale_r;

    if (cmd.finish) begin
      // back to the state after reset, waiting for a header
      step_nxt = ST_HEADER; zrun_nxt = '0; bidx_nxt = '0; lz_nxt = '0;
      acc_nxt = '0; rem_nxt = '0; loop_nxt = '0; spos_nxt = '0; nscale_nxt = 8'd8;
      wu_nxt = '0; hu_nxt = '0;
      for (int i = 0; i < 4; i++) crop_nxt[i] = '0;
      fmo_nxt = 1'b0; sep_nxt = 1'b0; sfx_nxt = 1'b0;
      prof_nxt = '0; lvl_nxt = '0; id_nxt = '0; chr_nxt = '0; err_nxt = '0;
    end else if (cmd.byte_step) begin
      if (step_r == ST_HEADER) begin
        if (byte_r[4:0] != 5'd7) begin
          err_nxt = STS_NOT_SPS; step_nxt = ST_DRAIN;
        end else if (!en_r) begin
          err_nxt = STS_SKIPPED; step_nxt = ST_DRAIN;
        end else begin
          step_nxt = ST_FIXED; bidx_nxt = '0; zrun_nxt = '0; chr_nxt = 2'd1;
        end
      end else if (active) begin
        if (epb) begin
          zrun_nxt = '0;
        end else begin
          zrun_nxt = (byte_r != 8'd0) ? 2'd0 : ((zrun_r == 2'd2) ? 2'd2 : zrun_r + 2'd1);
          if (step_r == ST_FIXED) begin
            bidx_nxt = bidx_r + 2'd1;
            if (bidx_r == 2'd0) begin
              if (byte_r == 8'd0) begin
                err_nxt = STS_BAD_FLD; step_nxt = ST_DRAIN;
              end else prof_nxt = byte_r;
            end else if (bidx_r == 2'd1) begin
              if (byte_r[1:0] != 2'd0) begin
                err_nxt = STS_BAD_FLD; step_nxt = ST_DRAIN;
              end
            end else begin
              if (byte_r == 8'd0) begin
                err_nxt = STS_BAD_FLD; step_nxt = ST_DRAIN;
              end else begin
                lvl_nxt = byte_r; step_nxt = ST_SPS_ID;
              end
            end
          end
        end
      end
    end else if (cmd.bit_step && active) begin
      // Exp-Golomb prefix/suffix, or a single flag bit
      if (!is_ue(step_r)) begin
        tv_en = 1'b1; tv = {31'd0, bit_in};
      end else if (!sfx_r) begin
        if (!bit_in) begin
          lz_nxt = lz_r + 5'd1;
          if (lz_r == 5'd30) begin
            err_nxt = STS_TRUNC; step_nxt = ST_DRAIN;
          end
        end else if (lz_r == 5'd0) begin
          tv_en = 1'b1;
        end else begin
          sfx_nxt = 1'b1; rem_nxt = lz_r; acc_nxt = 32'd1;
        end
      end else begin
        rem_nxt = rem_r - 5'd1;
        if (rem_r == 5'd1) begin
          tv_en = 1'b1; tv = acc_s - 32'd1;
          sfx_nxt = 1'b0; lz_nxt = '0; acc_nxt = '0;
        end else acc_nxt = acc_s;
      end

      if (tv_en) begin
        unique case (step_r) inside
          ST_SPS_ID: begin
            if (tv > 32'd31) begin
              err_nxt = STS_BAD_FLD; step_nxt = ST_DRAIN;
            end else begin
              id_nxt = tv[4:0];
              step_nxt = high_profile(prof_r) ? ST_CHROMA : ST_FRAME_NUM;
            end
          end
          ST_CHROMA: begin
            if (tv > 32'd3) begin
              err_nxt = STS_BAD_FLD; step_nxt = ST_DRAIN;
            end else begin
              chr_nxt = tv[1:0];
              step_nxt = (tv[1:0] == 2'd3) ? ST_SEPARATE : ST_DEPTH_L;
            end
          end
          ST_SEPARATE: begin
            if (tv[0]) sep_nxt = 1'b1;
            step_nxt = ST_DEPTH_L;
          end
          ST_MATRIX: begin
            loop_nxt = '0;
            step_nxt = tv[0] ? ST_LIST_FLAG : ST_FRAME_NUM;
          end
          ST_LIST_FLAG: begin
            if (tv[0]) begin
              spos_nxt = '0; nscale_nxt = 8'd8; step_nxt = ST_LIST_DELTA;
            end else begin
              loop_nxt = lp1;
              step_nxt = (lp1 >= lists) ? ST_FRAME_NUM : ST_LIST_FLAG;
            end
          end
          ST_LIST_DELTA: begin
            // se(v) mapping of delta_scale, 8-bit wrap
            ns = tv[0] ? (nscale_r + tv[8:1] + 8'd1) : (nscale_r - tv[8:1]);
            nscale_nxt = ns;
            spos_nxt = sp1;
            if (ns == 8'd0 || sp1 >= ((loop_r < 8'd6) ? 7'd16 : 7'd64)) begin
              loop_nxt = lp1;
              step_nxt = (lp1 >= lists) ? ST_FRAME_NUM : ST_LIST_FLAG;
            end
          end
          ST_POC_TYPE: begin
            step_nxt = (tv == 32'd0) ? ST_POC_LSB :
                       ((tv == 32'd1) ? ST_POC_ZERO : ST_MAX_REF);
          end
          ST_POC_LSB: step_nxt = ST_MAX_REF;
          ST_POC_COUNT: begin
            if (tv > 32'd255) begin
              err_nxt = STS_BAD_FLD; step_nxt = ST_DRAIN;
            end else begin
              loop_nxt = tv[7:0];
              step_nxt = (tv == 32'd0) ? ST_MAX_REF : ST_POC_REF;
            end
          end
          ST_POC_REF: begin
            loop_nxt = loop_r - 8'd1;
            if (loop_r == 8'd1) step_nxt = ST_MAX_REF;
          end
          ST_WIDTH: begin
            wu_nxt = sat16(tv); step_nxt = ST_HEIGHT;
          end
          ST_HEIGHT: begin
            hu_nxt = sat16(tv); step_nxt = ST_FMO;
          end
          ST_FMO: begin
            if (tv[0]) fmo_nxt = 1'b1;
            step_nxt = tv[0] ? ST_DIRECT : ST_MBAFF;
          end
          ST_CROP_FLAG: step_nxt = tv[0] ? ST_CROP_L : ST_DONE;
          [ST_CROP_L:ST_CROP_B]: begin
            crop_nxt[crop_off[1:0]] = sat16(tv);
            step_nxt = step_r + 6'd1;
          end
          default: step_nxt = step_r + 6'd1;
        endcase
      end
    end
  end

  // final size check
  logic [22:0] fw, fh, crw, crh, w_c, h_c;
  logic [1:0]  cat;
  logic [2:0]  fin_sts;

  always_comb begin
    cat = sep_r ? 2'd0 : chr_r;
    fw  = {3'd0, 20'({4'd0, wu_r} + 20'd1) << 4};
    fh  = 23'({7'd0, hu_r} + 23'd1) << (fmo_r ? 4 : 5);
    crw = 23'({7'd0, crop_r[0]} + {7'd0, crop_r[1]}) << ((cat == 2'd1 || cat == 2'd2) ? 1 : 0);
    crh = 23'({7'd0, crop_r[2]} + {7'd0, crop_r[3]}) <<
          ((fmo_r ? 0 : 1) + ((cat == 2'd1) ? 1 : 0));
    w_c = fw - crw;
    h_c = fh - crh;
    if (err_r != STS_OK) fin_sts = err_r;
    else if (step_r != ST_DONE) fin_sts = STS_TRUNC;
    else if (crw >= fw || crh >= fh) fin_sts = STS_RANGE;
    else if (w_c > 23'(LIM) || h_c > 23'(LIM)) fin_sts = STS_RANGE;
    else fin_sts = STS_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      step_r <= ST_HEADER; zrun_r <= '0; bidx_r <= '0; lz_r <= '0;
      acc_r <= '0; rem_r <= '0; loop_r <= '0; spos_r <= '0; nscale_r <= 8'd8;
      wu_r <= '0; hu_r <= '0;
      for (int i = 0; i < 4; i++) crop_r[i] <= '0;
      fmo_r <= 1'b0; sep_r <= 1'b0; sfx_r <= 1'b0;
      prof_r <= '0; lvl_r <= '0; id_r <= '0; chr_r <= '0; err_r <= '0;
      last_r <= 1'b0;
    end else begin
      if (cfg_we) en_r <= cfg_wdata;
      step_r <= step_nxt; zrun_r <= zrun_nxt; bidx_r <= bidx_nxt; lz_r <= lz_nxt;
      acc_r <= acc_nxt; rem_r <= rem_nxt; loop_r <= loop_nxt; spos_r <= spos_nxt;
      nscale_r <= nscale_nxt; wu_r <= wu_nxt; hu_r <= hu_nxt;
      for (int i = 0; i < 4; i++) crop_r[i] <= crop_nxt[i];
      fmo_r <= fmo_nxt; sep_r <= sep_nxt; sfx_r <= sfx_nxt;
      prof_r <= prof_nxt; lvl_r <= lvl_nxt; id_r <= id_nxt; chr_r <= chr_nxt;
      err_r <= err_nxt;
      if (cmd.load) last_r <= last_byte;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) byte_r <= nal_byte;
    if (cmd.finish) begin
      status <= fin_sts;
      if (fin_sts == STS_OK) begin
        frame_width   <= w_c[15:0];
        frame_height  <= h_c[15:0];
        profile_code  <= prof_r;
        level_code    <= lvl_r;
        set_id        <= id_r;
        chroma_format <= chr_r;
      end else begin
        frame_width <= '0; frame_height <= '0; profile_code <= '0;
        level_code <= '0; set_id <= '0; chroma_format <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/sps_ctrl.sv =====
// Controller: sequences accept, byte step, eight bit steps when the walker needs bits, and result hand-off.
// Uses sps_pkg command/status types.
`default_nettype none
module sps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sps_pkg::sps_sts_t sts,
  output sps_pkg::sps_cmd_t      cmd
);
  import sps_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_BYTE, S_BITS, S_FIN} state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_BYTE: begin
        cmd.byte_step = 1'b1;
        in_ready = !sts.need_bits && !sts.last;
        if (sts.need_bits) begin
          cnt_nxt = 3'd7; state_nxt = S_BITS;
        end else if (sts.last) state_nxt = S_FIN;
        else state_nxt = S_IDLE;
      end
      S_BITS: begin
        cmd.bit_step = 1'b1;
        cmd.bit_sel  = cnt_r;
        cnt_nxt = cnt_r - 3'd1;
        in_ready = (cnt_r == 3'd0) && !sts.last;
        if (cnt_r == 3'd0) state_nxt = sts.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          cmd.finish = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.load = in_ready && in_valid;
    if (cmd.load) state_nxt = S_BYTE;
  end

  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/h264_sps_frame_size_parser.sv =====
// A header, profile/constraint/level, removed 0x03 or post-walker byte takes only a byte step;
// a coded byte takes a byte step, then one bit step per bit through the Exp-Golomb walker.
// A final byte adds a finish step (held while an earlier result waits) and an idle state;
// the result is valid after the finish; its register lets the next unit's bytes be taken meanwhile.
// Reset (rst_n low, synchronous): parse_enable=1, walker awaits a header.
// Top level: SPS frame-size parser; depends on sps_pkg, sps_if, sps_ctrl, sps_dp.
`default_nettype none
module h264_sps_frame_size_parser #(
  parameter int DIM_BITS = sps_pkg::DIM_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  sps_in_if.sink    in_ch,
  sps_out_if.source out_ch
);
  import sps_pkg::*;

  sps_cmd_t cmd;
  sps_sts_t sts;

  // controller: one byte step per item, then eight bit steps when the walker needs bits
  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: syntax walker state, size math and the result register
  sps_dp #(.DIM_BITS(DIM_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .nal_byte      (in_ch.nal_byte),
    .last_byte     (in_ch.last_byte),
    .cmd           (cmd),
    .sts           (sts),
    .status        (out_ch.status),
    .frame_width   (out_ch.frame_width),
    .frame_height  (out_ch.frame_height),
    .profile_code  (out_ch.profile_code),
    .level_code    (out_ch.level_code),
    .set_id        (out_ch.set_id),
    .chroma_format (out_ch.chroma_format)
  );

endmodule
`default_nettype wire

// ===== design/sps_chk.sv =====
// Port-level checker for the SPS parser, bound to the top level.
// Depends on sps_pkg status codes.
`default_nettype none
module sps_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [15:0] frame_width,
  input wire logic [15:0] frame_height,
  input wire logic [7:0]  profile_code
);
  import sps_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= STS_RANGE)
    else $error("undefined status code");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STS_OK |-> frame_width == 16'd0 && frame_height == 16'd0
      && profile_code == 8'd0)
    else $error("fields not cleared on error");

  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STS_OK |-> frame_width != 16'd0 && frame_height != 16'd0
      && profile_code != 8'd0)
    else $error("ok result with empty size");

endmodule

bind h264_sps_frame_size_parser sps_chk u_sps_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .frame_width  (out_ch.frame_width),
  .frame_height (out_ch.frame_height),
  .profile_code (out_ch.profile_code)
);
`default_nettype wire
